[rtl/buddhabrot_orbit_histogram_defines.svh]
// Assertion macros for the orbit histogram block.
`ifndef BUDDHABROT_ORBIT_HISTOGRAM_DEFINES_SVH
`define BUDDHABROT_ORBIT_HISTOGRAM_DEFINES_SVH
// Clocked implication checked outside reset.
`define BOH_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define BOH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/boh_pkg.sv]
// ----------------------------------------------------------------------------
// boh_pkg
// Types, constants and helpers shared by the orbit histogram block.
// ----------------------------------------------------------------------------
package boh_pkg;
    localparam int MAX_ITER_DEF = 1024;
    localparam int GRID_W_DEF   = 256;
    localparam int GRID_H_DEF   = 256;

    localparam int REG_IDX_W = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ESCAPE_LIMIT = 3'd0,
        REG_ESCAPE_THR   = 3'd1,
        REG_VIEW_MIN_RE  = 3'd2,
        REG_VIEW_MIN_IM  = 3'd3,
        REG_SCALE_RE     = 3'd4,
        REG_SCALE_IM     = 3'd5,
        REG_VIEW_WIDTH   = 3'd6,
        REG_VIEW_HEIGHT  = 3'd7
    } reg_idx_t;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic [7:0]         bin_col;
        logic [7:0]         bin_row;
    } sample_t;

    typedef struct packed {
        logic        escaped;
        logic [10:0] orbit_length;
        logic [31:0] bin_count;
        logic [31:0] max_count;
    } result_t;

    typedef struct packed {
        logic [10:0]        escape_limit;
        logic [30:0]        escape_threshold;
        logic signed [31:0] view_min_re;
        logic signed [31:0] view_min_im;
        logic [31:0]        scale_re;
        logic [31:0]        scale_im;
        logic [8:0]         view_width;
        logic [8:0]         view_height;
    } cfg_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [31:0]          data;
    } cfg_wr_t;

    // Operand selects for the shared multiplier
    typedef enum logic [2:0] {
        MUL_RR, MUL_II, MUL_RI, MUL_MAP_HI, MUL_MAP_LO
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_READ_WAIT,
        ST_IT_RR, ST_IT_II, ST_IT_RI, ST_IT_UPD,
        ST_MG_RR, ST_MG_II, ST_MG_CHK,
        ST_RP_FETCH, ST_RP_WAIT,
        ST_RP_XH, ST_RP_XL, ST_RP_YH, ST_RP_YL, ST_RP_CHK,
        ST_RP_RD, ST_RP_RDW, ST_RP_WR,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (x < -34'sd2147483648) r = 32'sh80000000;
        else                           r = x[31:0];
        return r;
    endfunction
endpackage

[rtl/boh_mul.sv]
// ----------------------------------------------------------------------------
// boh_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module boh_mul (
    input  logic               aclk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);
    logic signed [65:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

[rtl/boh_hist_mem.sv]
// ----------------------------------------------------------------------------
// boh_hist_mem
// Histogram count memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module boh_hist_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/buddhabrot_orbit_histogram.sv]
// ----------------------------------------------------------------------------
// buddhabrot_orbit_histogram
// Buddhabrot orbit accumulator with a saturating bin histogram.
// ----------------------------------------------------------------------------
// One item at a time. A read item fetches its bin and goes to the output. An
// accumulate item runs one shared 33x33 multiplier: each iteration issues
// three products for z*z and two for the magnitude, and when the orbit
// escapes each stored orbit point is then replayed (four partial products
// for the bin mapping plus a read-modify-write of the count memory, which is
// skipped when the point misses the view). After reset a clearing pass
// writes zero to every bin, one per cycle, with s_ready low; configuration
// writes are accepted throughout.
`include "buddhabrot_orbit_histogram_defines.svh"
module buddhabrot_orbit_histogram #(
    parameter int MAX_ITER = boh_pkg::MAX_ITER_DEF,
    parameter int GRID_W   = boh_pkg::GRID_W_DEF,
    parameter int GRID_H   = boh_pkg::GRID_H_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  boh_pkg::sample_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output boh_pkg::result_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  boh_pkg::cfg_wr_t cfg_data
);
    import boh_pkg::*;

    localparam int CW    = $clog2(GRID_W);
    localparam int RW    = $clog2(GRID_H);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int OAW   = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
    localparam int NW    = $clog2(MAX_ITER + 1);

    // ---------------- configuration registers ----------------
    cfg_t cfg_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_limit     <= 11'd256;
            cfg_reg.escape_threshold <= 31'd268435456;
            cfg_reg.view_min_re      <= 32'shF8000000;
            cfg_reg.view_min_im      <= 32'shF8000000;
            cfg_reg.scale_re         <= 32'd4194304;
            cfg_reg.scale_im         <= 32'd4194304;
            cfg_reg.view_width       <= 9'd256;
            cfg_reg.view_height      <= 9'd256;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_data.index))
                REG_ESCAPE_LIMIT: cfg_reg.escape_limit     <= cfg_data.data[10:0];
                REG_ESCAPE_THR:   cfg_reg.escape_threshold <= cfg_data.data[30:0];
                REG_VIEW_MIN_RE:  cfg_reg.view_min_re      <= cfg_data.data;
                REG_VIEW_MIN_IM:  cfg_reg.view_min_im      <= cfg_data.data;
                REG_SCALE_RE:     cfg_reg.scale_re         <= cfg_data.data;
                REG_SCALE_IM:     cfg_reg.scale_im         <= cfg_data.data;
                REG_VIEW_WIDTH:   cfg_reg.view_width       <= cfg_data.data[8:0];
                REG_VIEW_HEIGHT:  cfg_reg.view_height      <= cfg_data.data[8:0];
                default: ;
            endcase
        end
    end

    // Clamp limits against the built sizes
    logic [NW-1:0] lim_eff;
    logic [12:0]   wlim, hlim;
    always_comb begin
        lim_eff = (32'(cfg_reg.escape_limit) > MAX_ITER) ? NW'(MAX_ITER)
                                                          : NW'(cfg_reg.escape_limit);
        wlim = (32'(cfg_reg.view_width) > GRID_W) ? 13'(GRID_W) : 13'(cfg_reg.view_width);
        hlim = (32'(cfg_reg.view_height) > GRID_H) ? 13'(GRID_H) : 13'(cfg_reg.view_height);
    end

    // ---------------- datapath registers ----------------
    state_t state_reg, state_next;
    logic signed [31:0] zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [31:0] nr_reg, ni_reg;
    logic signed [65:0] acc_reg;          // general product accumulator
    logic signed [65:0] t_reg;            // re^2 hold during iteration
    logic [NW-1:0] iter_reg, n_reg, idx_reg;
    logic [AW:0]   clr_reg;
    logic          esc_reg;
    logic [7:0]    col_reg, row_reg;
    logic [31:0]   bin_reg, max_reg;
    logic [32:0]   dx_reg, dy_reg;        // positive diffs
    logic          okx_reg, oky_reg;
    logic [12:0]   bx_reg, by_reg;
    logic          m_valid_reg;
    result_t       m_data_reg;

    // orbit store: one write and one registered read port
    logic [63:0] orbit_mem [MAX_ITER];
    logic [63:0] orbit_rd_reg;
    logic        orbit_we;

    always_ff @(posedge aclk) begin
        if (orbit_we) begin
            orbit_mem[n_reg[OAW-1:0]] <= {nr_reg, ni_reg};
        end
        orbit_rd_reg <= orbit_mem[idx_reg[OAW-1:0]];
    end

    // ---------------- shared multiplier ----------------
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    boh_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(prod));

    // ---------------- histogram memory ----------------
    logic          hm_we;
    logic [AW-1:0] hm_waddr, hm_raddr;
    logic [31:0]   hm_wdata, hm_rdata;
    boh_hist_mem #(.DEPTH(DEPTH), .AW(AW)) u_hist (
        .aclk(aclk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
        .raddr(hm_raddr), .rdata(hm_rdata)
    );

    logic [AW-1:0] bin_addr;
    assign bin_addr = {bx_reg[CW-1:0], by_reg[RW-1:0]};

    // Next point from the held products
    logic signed [65:0] diff_rr_ii;
    logic signed [31:0] nr_c, ni_c;
    logic signed [33:0] nr_s, ni_s;
    always_comb begin
        diff_rr_ii = t_reg - acc_reg;
        nr_s = 34'(diff_rr_ii >>> 26) + 34'(cr_reg);
        ni_s = 34'(prod >>> 25) + 34'(ci_reg);
        nr_c = sat32(nr_s);
        ni_c = sat32(ni_s);
    end

    // Map value: (hi*scale + (lo*scale >> 16)) >> 26
    logic [65:0] map_val;
    assign map_val = 66'((acc_reg + (prod >>> 16)) >>> 26);

    logic rd_in_grid;
    assign rd_in_grid = (32'(col_reg) < GRID_W) && (32'(row_reg) < GRID_H);

    logic signed [32:0] px_diff, py_diff;
    assign px_diff = 33'(signed'(orbit_rd_reg[63:32])) - 33'(cfg_reg.view_min_re);
    assign py_diff = 33'(signed'(orbit_rd_reg[31:0])) - 33'(cfg_reg.view_min_im);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        orbit_we   = 1'b0;
        hm_we      = 1'b0;
        hm_waddr   = bin_addr;
        hm_wdata   = '0;
        hm_raddr   = bin_addr;
        case (state_reg)
            ST_CLEAR: begin
                hm_we    = 1'b1;
                hm_waddr = clr_reg[AW-1:0];
                if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.operation == OP_READ) ? ST_READ : ST_IT_RR;
                end
            end
            ST_READ: begin
                hm_raddr   = {CW'(col_reg), RW'(row_reg)};
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT: state_next = ST_OUT;
            ST_IT_RR: begin
                if (iter_reg >= lim_eff) begin
                    state_next = ST_OUT;
                end else begin
                    mul_a = 33'(zr_reg); mul_b = 33'(zr_reg);
                    state_next = ST_IT_II;
                end
            end
            ST_IT_II: begin
                mul_a = 33'(zi_reg); mul_b = 33'(zi_reg);
                state_next = ST_IT_RI;
            end
            ST_IT_RI: begin
                mul_a = 33'(zr_reg); mul_b = 33'(zi_reg);
                state_next = ST_IT_UPD;
            end
            ST_IT_UPD: state_next = ST_MG_RR;
            ST_MG_RR: begin
                mul_a = 33'(nr_reg); mul_b = 33'(nr_reg);
                state_next = ST_MG_II;
            end
            ST_MG_II: begin
                mul_a = 33'(ni_reg); mul_b = 33'(ni_reg);
                state_next = ST_MG_CHK;
            end
            ST_MG_CHK: begin
                if (((acc_reg + prod) >>> 26) >= 66'(cfg_reg.escape_threshold)) begin
                    state_next = ST_RP_FETCH;
                end else begin
                    orbit_we   = 1'b1;
                    state_next = ST_IT_RR;
                end
            end
            ST_RP_FETCH: begin
                state_next = (idx_reg >= n_reg) ? ST_OUT : ST_RP_WAIT;
            end
            ST_RP_WAIT: state_next = ST_RP_XH;
            ST_RP_XH: begin
                mul_a = signed'({16'd0, dx_reg[32:16]});
                mul_b = signed'({1'b0, cfg_reg.scale_re});
                state_next = ST_RP_XL;
            end
            ST_RP_XL: begin
                mul_a = signed'({17'd0, dx_reg[15:0]});
                mul_b = signed'({1'b0, cfg_reg.scale_re});
                state_next = ST_RP_YH;
            end
            ST_RP_YH: begin
                mul_a = signed'({16'd0, dy_reg[32:16]});
                mul_b = signed'({1'b0, cfg_reg.scale_im});
                state_next = ST_RP_YL;
            end
            ST_RP_YL: begin
                mul_a = signed'({17'd0, dy_reg[15:0]});
                mul_b = signed'({1'b0, cfg_reg.scale_im});
                state_next = ST_RP_CHK;
            end
            ST_RP_CHK: state_next = ST_RP_RD;
            ST_RP_RD: begin
                state_next = (okx_reg && oky_reg) ? ST_RP_RDW : ST_RP_FETCH;
            end
            ST_RP_RDW: state_next = ST_RP_WR;
            ST_RP_WR: begin
                hm_we      = 1'b1;
                hm_wdata   = (hm_rdata == 32'hFFFFFFFF) ? hm_rdata : hm_rdata + 32'd1;
                state_next = ST_RP_FETCH;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Datapath updates per state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: begin
                    cr_reg   <= s_data.c_re;
                    ci_reg   <= s_data.c_im;
                    col_reg  <= s_data.bin_col;
                    row_reg  <= s_data.bin_row;
                    zr_reg   <= '0;
                    zi_reg   <= '0;
                    iter_reg <= '0;
                    n_reg    <= '0;
                    idx_reg  <= '0;
                    esc_reg  <= 1'b0;
                    bin_reg  <= '0;
                end
                ST_READ_WAIT: bin_reg <= rd_in_grid ? hm_rdata : 32'd0;
                ST_IT_II:  t_reg  <= prod;      // re^2
                ST_IT_RI:  acc_reg <= prod;     // im^2
                ST_IT_UPD: begin
                    nr_reg <= nr_c;
                    ni_reg <= ni_c;
                end
                ST_MG_II: acc_reg <= prod;      // nr^2
                ST_MG_CHK: begin
                    if (((acc_reg + prod) >>> 26) >= 66'(cfg_reg.escape_threshold)) begin
                        esc_reg <= 1'b1;
                    end else begin
                        n_reg    <= n_reg + 1'b1;
                        iter_reg <= iter_reg + 1'b1;
                        zr_reg   <= nr_reg;
                        zi_reg   <= ni_reg;
                    end
                end
                ST_RP_WAIT: begin
                    // orbit word now valid; form positive diffs
                    okx_reg <= (px_diff > 0);
                    oky_reg <= (py_diff > 0);
                    dx_reg  <= px_diff[32:0];
                    dy_reg  <= py_diff[32:0];
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_RP_XL:  acc_reg <= prod;     // hi*scale_re
                ST_RP_YH: begin
                    if (map_val == 0 || map_val >= 66'(wlim)) okx_reg <= 1'b0;
                    bx_reg <= map_val[12:0];
                end
                ST_RP_YL:  acc_reg <= prod;     // hi*scale_im
                ST_RP_CHK: begin
                    if (map_val == 0 || map_val >= 66'(hlim)) oky_reg <= 1'b0;
                    by_reg <= map_val[12:0];
                end
                ST_RP_WR: begin
                    if (hm_wdata > max_reg) max_reg <= hm_wdata;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.escaped      <= esc_reg;
                        m_data_reg.orbit_length <= esc_reg ? 11'(n_reg) : 11'd0;
                        m_data_reg.bin_count    <= bin_reg;
                        m_data_reg.max_count    <= (hm_we && hm_wdata > max_reg)
                                                   ? hm_wdata : max_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- checks ----------------
    `BOH_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, s_valid && s_ready, state_reg == ST_IDLE, "input taken while busy")
    `BOH_ASSERT_NEXT(a_out_after_issue, aclk, aresetn, state_reg == ST_OUT && !m_valid_reg, m_valid_reg, "result not issued")
    `BOH_ASSERT_IMPL(a_len_bound, aclk, aresetn, m_valid_reg, 32'(m_data_reg.orbit_length) <= MAX_ITER, "orbit length too long")
    `BOH_ASSERT_IMPL(a_read_no_esc, aclk, aresetn, state_reg == ST_READ, !esc_reg, "escape flag on read")
endmodule

[dv/tb_buddhabrot_orbit_histogram.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buddhabrot_orbit_histogram
// Self-checking bench for the orbit histogram: a scoreboard predicts every
// result from its own copy of the registers and the bin counts, while random
// sample and read items, register phases and gaps on both channels drive the
// block.
// ----------------------------------------------------------------------------
class orbit_scoreboard;
    logic [31:0]        counts [256*256];
    logic [10:0]        lim;
    logic [30:0]        thr;
    logic signed [31:0] min_re, min_im;
    logic [31:0]        scl_re, scl_im;
    logic [8:0]         wid, hgt;
    logic [31:0]        peak;
    boh_pkg::result_t   pending [$];
    int                 errors;

    function new();
        foreach (counts[k]) counts[k] = '0;
        lim = 11'd256; thr = 31'd268435456;
        min_re = 32'shF8000000; min_im = 32'shF8000000;
        scl_re = 32'd4194304; scl_im = 32'd4194304;
        wid = 9'd256; hgt = 9'd256;
        peak = '0; errors = 0;
    endfunction

    function void write_reg(boh_pkg::reg_idx_t idx, logic [31:0] v);
        case (idx)
            boh_pkg::REG_ESCAPE_LIMIT: lim    = v[10:0];
            boh_pkg::REG_ESCAPE_THR:   thr    = v[30:0];
            boh_pkg::REG_VIEW_MIN_RE:  min_re = v;
            boh_pkg::REG_VIEW_MIN_IM:  min_im = v;
            boh_pkg::REG_SCALE_RE:     scl_re = v;
            boh_pkg::REG_SCALE_IM:     scl_im = v;
            boh_pkg::REG_VIEW_WIDTH:   wid    = v[8:0];
            boh_pkg::REG_VIEW_HEIGHT:  hgt    = v[8:0];
            default: ;
        endcase
    endfunction

    static function logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // Bin along one axis; -1 when the point falls outside 1..top-1.
    static function int axis_bin(logic signed [31:0] p, logic signed [31:0] lo,
                                 logic [31:0] scl, int top);
        longint      diff;
        logic [63:0] d, v;
        diff = longint'(p) - longint'(lo);
        if (diff <= 0) return -1;
        d = diff;
        v = ((d >> 16) * scl + (((d & 64'hFFFF) * scl) >> 16)) >> 26;
        if (v == 0 || v >= top) return -1;
        return int'(v);
    endfunction

    function void note_sample(boh_pkg::sample_t s);
        boh_pkg::result_t   r;
        logic signed [31:0] zr, zi, nr, ni;
        logic signed [31:0] path_re [$], path_im [$];
        longint             rr, ii, ri;
        logic [63:0]        mag;
        int                 n_it, w_top, h_top, bc, br;
        r = '0;
        if (s.operation == boh_pkg::OP_READ) begin
            r.bin_count = counts[int'(s.bin_col) * 256 + int'(s.bin_row)];
        end else begin
            n_it  = (lim > 1024) ? 1024 : lim;
            w_top = (wid > 256) ? 256 : wid;
            h_top = (hgt > 256) ? 256 : hgt;
            zr = 0; zi = 0;
            for (int i = 0; i < n_it; i++) begin
                rr = longint'(zr) * zr; ii = longint'(zi) * zi; ri = longint'(zr) * zi;
                nr = clamp32(((rr - ii) >>> 26) + longint'(s.c_re));
                ni = clamp32((ri >>> 25) + longint'(s.c_im));
                mag = (64'(longint'(nr) * nr) + 64'(longint'(ni) * ni)) >> 26;
                if (mag >= thr) begin
                    r.escaped = 1'b1;
                    break;
                end
                path_re = {path_re, nr};
                path_im = {path_im, ni};
                zr = nr; zi = ni;
            end
            if (r.escaped) begin
                r.orbit_length = 11'(path_re.size());
                foreach (path_re[k]) begin
                    bc = axis_bin(path_re[k], min_re, scl_re, w_top);
                    br = axis_bin(path_im[k], min_im, scl_im, h_top);
                    if (bc >= 0 && br >= 0) begin
                        if (counts[bc*256+br] != 32'hFFFFFFFF)
                            counts[bc*256+br]++;
                        if (counts[bc*256+br] > peak) peak = counts[bc*256+br];
                    end
                end
            end
        end
        r.max_count = peak;
        pending = {pending, r};
    endfunction

    function void check_result(boh_pkg::result_t got);
        boh_pkg::result_t exp_r;
        if (pending.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.escaped !== exp_r.escaped) begin
            $display("%0t: escaped expected %0d actual %0d", $time, exp_r.escaped,
                     got.escaped);
            errors++;
        end
        if (got.orbit_length !== exp_r.orbit_length) begin
            $display("%0t: orbit_length expected %0d actual %0d", $time,
                     exp_r.orbit_length, got.orbit_length);
            errors++;
        end
        if (got.bin_count !== exp_r.bin_count) begin
            $display("%0t: bin_count expected %0d actual %0d", $time,
                     exp_r.bin_count, got.bin_count);
            errors++;
        end
        if (got.max_count !== exp_r.max_count) begin
            $display("%0t: max_count expected %0d actual %0d", $time,
                     exp_r.max_count, got.max_count);
            errors++;
        end
    endfunction
endclass

module tb_buddhabrot_orbit_histogram;
    import boh_pkg::*;

    localparam int HANG_LIMIT = 400000;  // clearing pass plus a full-length orbit, many times

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    sample_t s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    cfg_wr_t cfg_data = '0;

    orbit_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  drain_stall = 1'b1;   // lets the result side stall at random

    always #10 aclk = ~aclk;

    buddhabrot_orbit_histogram dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: check every transfer and choose ready for the next edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (!drain_stall) m_ready <= 1'b1;
        else              m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("** buddhabrot_orbit_histogram: FAILED **");
            $finish;
        end
    end

    // Drop valid for one edge after each transfer.
    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= '{index: idx, data: v};
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the item until it transfers, then note it in the scoreboard.
    task automatic send_item(sample_t s);
        int g;
        g = gap_len();
        repeat (g) @(posedge aclk);
        s_valid <= 1'b1;
        s_data  <= s;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(s);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic signed [31:0] re, logic signed [31:0] im);
        send_item('{operation: OP_ACCUMULATE, c_re: re, c_im: im,
                    bin_col: 8'($urandom), bin_row: 8'($urandom)});
    endtask

    task automatic send_read(logic [7:0] col, logic [7:0] row);
        send_item('{operation: OP_READ, c_re: 32'($urandom), c_im: 32'($urandom),
                    bin_col: col, bin_row: row});
    endtask

    // Wait for all results, then a settle pause before a register change.
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Random point, mostly in a window around the set.
    task automatic random_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 8)
            send_sample($signed($urandom_range(0, 32'h10000000)) - 32'sh0A000000,
                        $signed($urandom_range(0, 32'h0A000000)) - 32'sh05000000);
        else
            send_sample($urandom, $urandom);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                // Half of the reads hit the middle of the view where counts gather.
                if ($urandom_range(0, 1)) send_read($urandom_range(96, 160),
                                                    $urandom_range(96, 160));
                else                      send_read($urandom, $urandom);
            end else begin
                random_sample();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes and the special cases.
        send_read(8'd0, 8'd0);
        send_read(8'd255, 8'd255);
        send_sample(32'sh80000000, 32'sh80000000);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_sample(32'sh00000000, 32'sh00000000);   // never escapes
        send_sample(-32'sh04800000, 32'sh00400000);  // inside the set; runs to the iteration limit
        send_sample(-32'sh01000000, 32'sh02B00000);
        send_sample(32'sh01000000, 32'sh00000000);
        send_read(8'd128, 8'd128);
        wait_drained();
        write_reg(REG_ESCAPE_THR, 32'd0);            // first point escapes
        send_sample(32'sh01000000, 32'sh01000000);
        wait_drained();
        write_reg(REG_ESCAPE_LIMIT, 32'd0);          // no iteration at all
        write_reg(REG_ESCAPE_THR, 32'h7FFFFFFF);
        send_sample(32'sh01000000, 32'sh01000000);
        wait_drained();
        write_reg(REG_ESCAPE_LIMIT, 32'h7FF);        // clamped to the orbit store depth
        write_reg(REG_ESCAPE_THR, 32'd268435456);
        write_reg(REG_VIEW_HEIGHT, 32'h1FF);
        write_reg(REG_VIEW_WIDTH, 32'h1FF);          // view clamped to grid
        send_sample(-32'sh04800000, 32'sh00400000);
        send_sample(-32'sh01000000, 32'sh02B00000);
        wait_drained();

        // Tiny scale folds every point into bin 0, outside the view; saturate-free.
        write_reg(REG_ESCAPE_LIMIT, 32'd64);
        write_reg(REG_VIEW_MIN_RE, 32'h80000000);
        write_reg(REG_VIEW_MIN_IM, 32'h80000000);
        write_reg(REG_SCALE_RE, 32'h00000400);
        write_reg(REG_SCALE_IM, 32'h00000400);
        write_reg(REG_VIEW_WIDTH, 32'd2);
        write_reg(REG_VIEW_HEIGHT, 32'd2);
        random_phase(40);
        send_read(8'd1, 8'd1);
        wait_drained();

        // Huge scale and a narrow view.
        write_reg(REG_VIEW_MIN_RE, 32'h7FFFFFFF);
        write_reg(REG_VIEW_MIN_IM, 32'hF0000000);
        write_reg(REG_SCALE_RE, 32'hFFFFFFFF);
        write_reg(REG_SCALE_IM, 32'hFFFFFFFF);
        write_reg(REG_VIEW_WIDTH, 32'd1);
        write_reg(REG_VIEW_HEIGHT, 32'd256);
        random_phase(30);
        wait_drained();

        // Default view, bulk of the random stimulus with varied ready behavior.
        write_reg(REG_ESCAPE_LIMIT, 32'd48);
        write_reg(REG_ESCAPE_THR, 32'd268435456);
        write_reg(REG_VIEW_MIN_RE, 32'hF8000000);
        write_reg(REG_VIEW_MIN_IM, 32'hF8000000);
        write_reg(REG_SCALE_RE, 32'd4194304);
        write_reg(REG_SCALE_IM, 32'd4194304);
        write_reg(REG_VIEW_WIDTH, 32'd256);
        write_reg(REG_VIEW_HEIGHT, 32'd256);
        random_phase(100);
        drain_stall = 1'b0;
        random_phase(40);
        drain_stall = 1'b1;
        wait_drained();

        // Random registers for the last stretch.
        write_reg(REG_ESCAPE_LIMIT, $urandom_range(1, 40));
        write_reg(REG_ESCAPE_THR, $urandom_range(32'h01000000, 32'h7FFFFFFF));
        write_reg(REG_VIEW_MIN_RE, $urandom);
        write_reg(REG_VIEW_MIN_IM, 32'hF8000000 + $urandom_range(0, 32'h01000000));
        write_reg(REG_SCALE_RE, $urandom);
        write_reg(REG_SCALE_IM, $urandom_range(1, 32'h01000000));
        write_reg(REG_VIEW_WIDTH, $urandom_range(1, 511));
        write_reg(REG_VIEW_HEIGHT, $urandom_range(1, 511));
        random_phase(60);

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0)
            $display("** buddhabrot_orbit_histogram: PASSED **");
        else
            $display("** buddhabrot_orbit_histogram: FAILED **");
        $finish;
    end
endmodule

[buddhabrot_orbit_histogram.f]
+incdir+rtl
rtl/boh_pkg.sv
rtl/boh_mul.sv
rtl/boh_hist_mem.sv
rtl/buddhabrot_orbit_histogram.sv
dv/tb_buddhabrot_orbit_histogram.sv
